// ===== rtl/bgd_pkg.sv =====
package bgd_pkg;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_DOUBLE_GAP = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        G_NONE   = 2'd0,
        G_SHORT  = 2'd1,
        G_DOUBLE = 2'd2,
        G_LONG   = 2'd3
    } t_gesture;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] double_gap_ms;
    } t_cfg;

    localparam logic        ACT_UPDATE = 1'b0;
    localparam logic        ACT_INIT   = 1'b1;

    localparam logic [15:0] DEBOUNCE_RESET   = 16'd30;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd800;
    localparam logic [15:0] DOUBLE_GAP_RESET = 16'd300;

endpackage

// ===== rtl/bgd_step.sv =====
module bgd_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_action,
    input  logic [31:0]        i_now_ms,
    input  logic               i_pressed,
    input  bgd_pkg::t_cfg      i_cfg,
    output bgd_pkg::t_gesture  o_gesture,
    output logic [31:0]        o_bounce_count
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_FIRST   = 2'd1,
        PH_WAIT2   = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_raw, n_raw;
    logic [31:0] r_raw_time, n_raw_time;
    logic        r_stable, n_stable;
    logic [31:0] r_edge_time, n_edge_time;
    logic [31:0] r_bounces, n_bounces;

    logic        changed;
    logic        confirm;
    logic        press_edge;
    logic        release_edge;
    logic [31:0] raw_elapsed;
    logic [31:0] edge_elapsed;
    bgd_pkg::t_gesture gesture;

    always_comb begin
        changed      = i_pressed != r_raw;
        raw_elapsed  = changed ? 32'd0 : (i_now_ms - r_raw_time);
        edge_elapsed = i_now_ms - r_edge_time;
        confirm      = (i_pressed != r_stable) &&
                       (raw_elapsed >= {16'd0, i_cfg.debounce_ms});
        press_edge   = confirm && i_pressed;
        release_edge = confirm && !i_pressed;

        n_raw       = i_pressed;
        n_raw_time  = changed ? i_now_ms : r_raw_time;
        n_bounces   = r_bounces + {31'd0, changed && (r_raw != r_stable)};
        n_stable    = confirm ? i_pressed : r_stable;
        n_edge_time = r_edge_time;
        n_phase     = r_phase;
        gesture     = bgd_pkg::G_NONE;

        case (r_phase)
            PH_IDLE: begin
                if (press_edge) begin
                    n_phase     = PH_FIRST;
                    n_edge_time = i_now_ms;
                end
            end
            PH_FIRST: begin
                if (release_edge) begin
                    n_phase     = PH_WAIT2;
                    n_edge_time = i_now_ms;
                end else if (edge_elapsed >= {16'd0, i_cfg.long_press_ms}) begin
                    n_phase = PH_RELEASE;
                    gesture = bgd_pkg::G_LONG;
                end
            end
            PH_WAIT2: begin
                if (press_edge) begin
                    n_phase = PH_RELEASE;
                    gesture = bgd_pkg::G_DOUBLE;
                end else if (edge_elapsed >= {16'd0, i_cfg.double_gap_ms}) begin
                    n_phase = PH_IDLE;
                    gesture = bgd_pkg::G_SHORT;
                end
            end
            default: begin
                if (release_edge) begin
                    n_phase = PH_IDLE;
                end
            end
        endcase

        if (i_action) begin
            n_raw       = i_pressed;
            n_stable    = i_pressed;
            n_raw_time  = i_now_ms;
            n_edge_time = i_now_ms;
            n_bounces   = 32'd0;
            n_phase     = i_pressed ? PH_RELEASE : PH_IDLE;
            gesture     = bgd_pkg::G_NONE;
        end
    end

    assign o_gesture      = gesture;
    assign o_bounce_count = n_bounces;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_raw       <= 1'b0;
            r_raw_time  <= 32'd0;
            r_stable    <= 1'b0;
            r_edge_time <= 32'd0;
            r_bounces   <= 32'd0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_raw       <= n_raw;
            r_raw_time  <= n_raw_time;
            r_stable    <= n_stable;
            r_edge_time <= n_edge_time;
            r_bounces   <= n_bounces;
        end
    end

endmodule

// ===== rtl/button_gesture_detector.sv =====
// Each item is registered in the input stage, then its result in the result stage;
// the debounce and gesture state update as an item moves from one to the other.
// Throughput: one item per cycle unless the output stalls.
// Reset (synchronous, active low): gesture phase idle, levels, time stamps and bounce count
// zero, debounce_ms 30, long_press_ms 800, double_gap_ms 300, both stages empty.
module button_gesture_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [31:0] i_now_ms,
    input  logic        i_pressed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_gesture,
    output logic [31:0] o_bounce_count
);

    bgd_pkg::t_cfg     r_cfg;
    logic              r_in_valid;
    logic              r_in_action;
    logic [31:0]       r_in_now_ms;
    logic              r_in_pressed;
    logic              r_out_valid;
    logic [1:0]        r_out_gesture;
    logic [31:0]       r_out_bounce_count;

    logic              out_free;
    logic              advance;
    logic              accept;
    bgd_pkg::t_gesture step_gesture;
    logic [31:0]       step_bounce_count;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= bgd_pkg::DEBOUNCE_RESET;
            r_cfg.long_press_ms <= bgd_pkg::LONG_PRESS_RESET;
            r_cfg.double_gap_ms <= bgd_pkg::DOUBLE_GAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bgd_pkg::CFG_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg_data;
                bgd_pkg::CFG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                bgd_pkg::CFG_DOUBLE_GAP: r_cfg.double_gap_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_action  <= i_action;
            r_in_now_ms  <= i_now_ms;
            r_in_pressed <= i_pressed;
        end
    end

    bgd_step u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_action       (r_in_action),
        .i_now_ms       (r_in_now_ms),
        .i_pressed      (r_in_pressed),
        .i_cfg          (r_cfg),
        .o_gesture      (step_gesture),
        .o_bounce_count (step_bounce_count)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_gesture      <= step_gesture;
            r_out_bounce_count <= step_bounce_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_gesture      = r_out_gesture;
    assign o_bounce_count = r_out_bounce_count;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stalled with empty input stage");

    a_item_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("item left input stage but no result valid");

    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_action) |=> (o_bounce_count == 32'd0 &&
                                      o_gesture == bgd_pkg::G_NONE))
        else $error("init item gave nonzero result");

endmodule

// ===== bench/button_gesture_detector_checker.sv =====
module button_gesture_detector_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_action,
    input  logic [31:0] i_now_ms,
    input  logic        i_pressed,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_gesture,
    input  logic [31:0] i_bounce_count,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST_PRESS,
        PH_WAIT_SECOND,
        PH_WAIT_RELEASE
    } t_phase;

    typedef struct packed {
        bgd_pkg::t_gesture gesture;
        logic [31:0]       bounce_count;
    } t_press_result;

    bgd_pkg::t_cfg thresholds;
    t_phase        phase;
    logic          raw_level;
    logic          stable_level;
    logic [31:0]   raw_change_ms;
    logic [31:0]   edge_ms;
    logic [31:0]   bounces;
    t_press_result expected_presses[$];
    t_press_result want;
    int            fail_count = 0;

    task automatic report_fault(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic t_press_result track_press(logic act, logic [31:0] now, logic lvl);
        t_press_result res;
        logic          press_edge;
        logic          release_edge;
        logic [31:0]   held;
        res.gesture  = bgd_pkg::G_NONE;
        press_edge   = 1'b0;
        release_edge = 1'b0;
        if (act == bgd_pkg::ACT_INIT) begin
            raw_level     = lvl;
            stable_level  = lvl;
            raw_change_ms = now;
            edge_ms       = now;
            bounces       = '0;
            phase         = lvl ? PH_WAIT_RELEASE : PH_IDLE;
        end else begin
            if (lvl != raw_level) begin
                if (raw_level != stable_level) begin
                    bounces = bounces + 32'd1;
                end
                raw_level     = lvl;
                raw_change_ms = now;
            end
            held = now - raw_change_ms;
            if (raw_level != stable_level && held >= {16'd0, thresholds.debounce_ms}) begin
                stable_level = raw_level;
                press_edge   = stable_level;
                release_edge = !stable_level;
            end
            held = now - edge_ms;
            case (phase)
                PH_IDLE: begin
                    if (press_edge) begin
                        phase   = PH_FIRST_PRESS;
                        edge_ms = now;
                    end
                end
                PH_FIRST_PRESS: begin
                    if (release_edge) begin
                        phase   = PH_WAIT_SECOND;
                        edge_ms = now;
                    end else if (held >= {16'd0, thresholds.long_press_ms}) begin
                        phase       = PH_WAIT_RELEASE;
                        res.gesture = bgd_pkg::G_LONG;
                    end
                end
                PH_WAIT_SECOND: begin
                    if (press_edge) begin
                        phase       = PH_WAIT_RELEASE;
                        res.gesture = bgd_pkg::G_DOUBLE;
                    end else if (held >= {16'd0, thresholds.double_gap_ms}) begin
                        phase       = PH_IDLE;
                        res.gesture = bgd_pkg::G_SHORT;
                    end
                end
                default: begin
                    if (release_edge) begin
                        phase = PH_IDLE;
                    end
                end
            endcase
        end
        res.bounce_count = bounces;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thresholds.debounce_ms   = bgd_pkg::DEBOUNCE_RESET;
            thresholds.long_press_ms = bgd_pkg::LONG_PRESS_RESET;
            thresholds.double_gap_ms = bgd_pkg::DOUBLE_GAP_RESET;
            phase         = PH_IDLE;
            raw_level     = 1'b0;
            stable_level  = 1'b0;
            raw_change_ms = '0;
            edge_ms       = '0;
            bounces       = '0;
            expected_presses.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_presses.size() == 0) begin
                    report_fault($sformatf("unexpected item: gesture %0d bounce_count %0d",
                                           i_gesture, i_bounce_count));
                end else begin
                    want = expected_presses.pop_front();
                    if (i_gesture !== want.gesture) begin
                        report_fault($sformatf("gesture: got %0d, want %0d",
                                               i_gesture, want.gesture));
                    end
                    if (i_bounce_count !== want.bounce_count) begin
                        report_fault($sformatf("bounce_count: got %0d, want %0d",
                                               i_bounce_count, want.bounce_count));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bgd_pkg::CFG_DEBOUNCE:   thresholds.debounce_ms   = i_cfg_data;
                    bgd_pkg::CFG_LONG_PRESS: thresholds.long_press_ms = i_cfg_data;
                    bgd_pkg::CFG_DOUBLE_GAP: thresholds.double_gap_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_presses.push_back(track_press(i_action, i_now_ms, i_pressed));
            end
        end
        o_pending    = expected_presses.size();
        o_fail_count = fail_count;
    end

endmodule

// ===== bench/button_gesture_detector_test.sv =====
module button_gesture_detector_test;

    localparam int   CYCLE_LIMIT   = 400000;
    localparam int   SETTLE_CYCLES = 4;
    localparam int   RANDOM_ITEMS  = 290;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [31:0] now_ms;
    logic        pressed;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  gesture;
    logic [31:0] bounce_count;

    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned sent_items = 0;
    int unsigned cfg_debounce = {16'd0, bgd_pkg::DEBOUNCE_RESET};
    int unsigned cfg_long = {16'd0, bgd_pkg::LONG_PRESS_RESET};
    int unsigned cfg_gap = {16'd0, bgd_pkg::DOUBLE_GAP_RESET};
    logic [31:0] stamp_ms;
    logic        btn;

    button_gesture_detector dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_action       (action),
        .i_now_ms       (now_ms),
        .i_pressed      (pressed),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_gesture      (gesture),
        .o_bounce_count (bounce_count)
    );

    button_gesture_detector_checker gesture_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_action       (action),
        .i_now_ms       (now_ms),
        .i_pressed      (pressed),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_gesture      (gesture),
        .i_bounce_count (bounce_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(logic act, logic [31:0] stamp, logic lvl);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        action   <= act;
        now_ms   <= stamp;
        pressed  <= lvl;
        do @(posedge clk); while (in_stall);
        sent_items++;
    endtask

    // drop valid, wait for every expected item, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_thresholds(logic [15:0] deb, logic [15:0] lng, logic [15:0] gap);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= bgd_pkg::CFG_DEBOUNCE;
        cfg_data  <= deb;
        @(posedge clk);
        cfg_index <= bgd_pkg::CFG_LONG_PRESS;
        cfg_data  <= lng;
        @(posedge clk);
        cfg_index <= bgd_pkg::CFG_DOUBLE_GAP;
        cfg_data  <= gap;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_debounce = {16'd0, deb};
        cfg_long     = {16'd0, lng};
        cfg_gap      = {16'd0, gap};
    endtask

    task automatic run_random(int unsigned count);
        int unsigned last;
        int unsigned span;
        int unsigned quick;
        int unsigned roll;
        int unsigned bursts;
        last  = sent_items + count;
        span  = cfg_long + cfg_gap + 1;
        quick = (cfg_debounce > 0) ? cfg_debounce - 1 : 0;
        while (sent_items < last) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                btn = 1'($urandom_range(1));
                send_item(bgd_pkg::ACT_INIT, stamp_ms, btn);
            end else if (roll < 6) begin
                stamp_ms = $urandom;
                send_item(bgd_pkg::ACT_UPDATE, stamp_ms, 1'($urandom_range(1)));
            end else if (roll < 8) begin
                stamp_ms = stamp_ms - $urandom_range(quick + 20);
                send_item(bgd_pkg::ACT_UPDATE, stamp_ms, btn);
            end else if (roll < 25) begin
                btn    = ~btn;
                bursts = 2 * $urandom_range(2) + 1;
                for (int k = 0; k < bursts; k++) begin
                    stamp_ms = stamp_ms + $urandom_range(quick);
                    send_item(bgd_pkg::ACT_UPDATE, stamp_ms, (k % 2 == 1) ? ~btn : btn);
                end
            end else begin
                if ($urandom_range(1) == 1) begin
                    stamp_ms = stamp_ms + $urandom_range(cfg_debounce + 8);
                end else begin
                    stamp_ms = stamp_ms + $urandom_range(span / 2);
                end
                send_item(bgd_pkg::ACT_UPDATE, stamp_ms, btn);
            end
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= bgd_pkg::CFG_DEBOUNCE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        action    <= bgd_pkg::ACT_UPDATE;
        now_ms    <= '0;
        pressed   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_item(bgd_pkg::ACT_INIT,   32'd0,    1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1000, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1010, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1015, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1045, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1100, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1130, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1430, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1500, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1530, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1560, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1590, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1600, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1630, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1700, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd1730, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd2000, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd2030, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd2830, 1'b1);
        // time stamps wrap through zero, then step back
        send_item(bgd_pkg::ACT_INIT,   32'hFFFF_FFF0, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'h0000_001E, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'h0000_0020, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'h0000_0040, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'h0000_0010, 1'b1);

        load_thresholds(16'd0, 16'd0, 16'd0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd5000, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd5000, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd5001, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd5002, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd5003, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd5003, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd5004, 1'b1);
        send_item(bgd_pkg::ACT_UPDATE, 32'd5005, 1'b0);
        send_item(bgd_pkg::ACT_UPDATE, 32'd5006, 1'b1);

        send_idle_pct = 31;
        recv_idle_pct = 52;
        load_thresholds(16'($urandom_range(40)), 16'($urandom_range(900, 50)),
                        16'($urandom_range(400, 20)));
        stamp_ms = $urandom;
        btn      = 1'b0;
        send_item(bgd_pkg::ACT_INIT, stamp_ms, btn);
        run_random(RANDOM_ITEMS);

        send_idle_pct = 52;
        recv_idle_pct = 31;
        load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        stamp_ms = 32'hFFF0_0000;
        btn      = 1'b0;
        send_item(bgd_pkg::ACT_INIT, stamp_ms, btn);
        run_random(RANDOM_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_thresholds(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                        16'($urandom_range(65535)));
        stamp_ms = $urandom;
        btn      = 1'b1;
        send_item(bgd_pkg::ACT_INIT, stamp_ms, btn);
        run_random(RANDOM_ITEMS);

        settle();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== button_gesture_detector.f =====
rtl/bgd_pkg.sv
rtl/bgd_step.sv
rtl/button_gesture_detector.sv
bench/button_gesture_detector_checker.sv
bench/button_gesture_detector_test.sv
